@@ sv/igds_pkg.sv @@
// ----------------------------------------------------------------------------
// igds_pkg
// Shared types, constants and angle helpers for the ignition dwell scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package igds_pkg;

  localparam int DEF_NUM_COILS  = 8;
  localparam int DEF_ANGLE_BITS = 15;

  localparam int COIL_W    = 3;
  localparam int FIELD_W   = 15;
  localparam int DWELL_W   = 16;
  localparam int TDC_W     = 14;
  localparam int RATIO_W   = 8;
  localparam int WDOG_W    = 32;
  localparam int ANG_MAX_W = 16;  // widest internal angle

  localparam int QUEUE_DEPTH = 2;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ENGINE_CYCLE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TDC_OFFSET   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DWELL_LIMIT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_RATIO  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_RATIO = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_WATCHDOG     = 3'd5;

  localparam logic [FIELD_W-1:0] RST_ENGINE_CYCLE = 15'd7200;
  localparam logic [TDC_W-1:0]   RST_TDC_OFFSET   = 14'd600;
  localparam logic [FIELD_W-1:0] RST_DWELL_LIMIT  = 15'd3600;
  localparam logic [RATIO_W-1:0] RST_FIRST_RATIO  = 8'd102;
  localparam logic [RATIO_W-1:0] RST_SECOND_RATIO = 8'd230;
  localparam logic [WDOG_W-1:0]  RST_WATCHDOG     = 32'd0;

  typedef struct packed {
    logic [COIL_W-1:0]  coil_index;
    logic [FIELD_W-1:0] min_advance_angle;
    logic [FIELD_W-1:0] applied_advance;
    logic [FIELD_W-1:0] crank_angle;
    logic [DWELL_W-1:0] dwell_angle;
  } tooth_t;

  typedef struct packed {
    logic [COIL_W-1:0]  coil_out;
    logic               immediate_trigger;
    logic [FIELD_W-1:0] start_angle;
    logic [FIELD_W-1:0] end_angle;
    logic [FIELD_W-1:0] slope_one_rel;
    logic [FIELD_W-1:0] slope_two_rel;
    logic [FIELD_W-1:0] slope_one_abs;
    logic [FIELD_W-1:0] slope_two_abs;
    logic [WDOG_W-1:0]  watchdog_delay;
  } sched_t;

  typedef struct packed {
    logic [FIELD_W-1:0] engine_cycle_angle;
    logic [TDC_W-1:0]   tdc_offset_angle;
    logic [FIELD_W-1:0] dwell_angle_limit;
    logic [RATIO_W-1:0] first_slope_ratio;
    logic [RATIO_W-1:0] second_slope_ratio;
    logic [WDOG_W-1:0]  watchdog_limit;
  } cfg_t;

  // a - b, plus one engine cycle if negative; callers truncate to their width
  function automatic logic [ANG_MAX_W-1:0] wrap_diff(input logic [ANG_MAX_W-1:0] a,
                                                     input logic [ANG_MAX_W-1:0] b,
                                                     input logic [FIELD_W-1:0] cyc);
    logic [ANG_MAX_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[ANG_MAX_W-1:0] + (d[ANG_MAX_W] ? ANG_MAX_W'(cyc) : '0);
  endfunction

  // one conditional subtract of the engine cycle
  function automatic logic [ANG_MAX_W-1:0] reduce_once(input logic [ANG_MAX_W-1:0] v,
                                                       input logic [FIELD_W-1:0] cyc);
    if ({1'b0, v} >= {2'b00, cyc}) begin
      return v - ANG_MAX_W'(cyc);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/igds_if.sv @@
// ----------------------------------------------------------------------------
// igds_if
// Valid/ready channels for tooth events and schedule results.
// ----------------------------------------------------------------------------
`default_nettype none

interface igds_tooth_if import igds_pkg::*; ();
  logic   valid;
  logic   ready;
  tooth_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface igds_sched_if import igds_pkg::*; ();
  logic   valid;
  logic   ready;
  sched_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/ignition_dwell_angle_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// ignition_dwell_angle_scheduler_core
// Path: an event transfer is written to the queue, then passes the window
//   stage, multiply stage and result register. Throughput: one event per
//   cycle unless stalled; every stage and the 2-entry queue move one item
//   per cycle. Events outside the look-ahead window or for an unknown coil
//   give no result. rst (synchronous) empties the pipe, loads defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ignition_dwell_angle_scheduler_core import igds_pkg::*; #(
  parameter int NUM_COILS  = DEF_NUM_COILS,
  parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  igds_tooth_if.sink            tooth,
  igds_sched_if.source          sched
);

  localparam int ENTRY_W = COIL_W + 4 * ANGLE_BITS;

  cfg_t               cfg;
  logic               push;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop;
  logic               head_valid;
  logic [ENTRY_W-1:0] head_data;

  igds_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  igds_front #(
    .NUM_COILS  (NUM_COILS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .tooth      (tooth),
    .cfg        (cfg),
    .push_ready (push_ready),
    .push       (push),
    .push_data  (push_data)
  );

  igds_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  igds_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .sched      (sched)
  );

endmodule

`default_nettype wire

@@ sv/igds_regs.sv @@
// ----------------------------------------------------------------------------
// igds_regs
// APB configuration registers, one per 32-bit word.
// ----------------------------------------------------------------------------
`default_nettype none

module igds_regs import igds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  // byte lanes ignored, word index only
  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.engine_cycle_angle <= RST_ENGINE_CYCLE;
      cfg.tdc_offset_angle   <= RST_TDC_OFFSET;
      cfg.dwell_angle_limit  <= RST_DWELL_LIMIT;
      cfg.first_slope_ratio  <= RST_FIRST_RATIO;
      cfg.second_slope_ratio <= RST_SECOND_RATIO;
      cfg.watchdog_limit     <= RST_WATCHDOG;
    end else if (wr_en) begin
      unique case (idx)
        REG_ENGINE_CYCLE: cfg.engine_cycle_angle <= pwdata[FIELD_W-1:0];
        REG_TDC_OFFSET:   cfg.tdc_offset_angle   <= pwdata[TDC_W-1:0];
        REG_DWELL_LIMIT:  cfg.dwell_angle_limit  <= pwdata[FIELD_W-1:0];
        REG_FIRST_RATIO:  cfg.first_slope_ratio  <= pwdata[RATIO_W-1:0];
        REG_SECOND_RATIO: cfg.second_slope_ratio <= pwdata[RATIO_W-1:0];
        REG_WATCHDOG:     cfg.watchdog_limit     <= pwdata[WDOG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENGINE_CYCLE: prdata = APB_DATA_W'(cfg.engine_cycle_angle);
      REG_TDC_OFFSET:   prdata = APB_DATA_W'(cfg.tdc_offset_angle);
      REG_DWELL_LIMIT:  prdata = APB_DATA_W'(cfg.dwell_angle_limit);
      REG_FIRST_RATIO:  prdata = APB_DATA_W'(cfg.first_slope_ratio);
      REG_SECOND_RATIO: prdata = APB_DATA_W'(cfg.second_slope_ratio);
      REG_WATCHDOG:     prdata = APB_DATA_W'(cfg.watchdog_limit);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/igds_front.sv @@
// ----------------------------------------------------------------------------
// igds_front
// Takes tooth events, drops unknown coils, forms spark angle and clamped dwell.
// ----------------------------------------------------------------------------
`default_nettype none

module igds_front import igds_pkg::*; #(
  parameter int NUM_COILS  = DEF_NUM_COILS,
  parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
  igds_tooth_if.sink                         tooth,
  input  cfg_t                               cfg,
  input  logic                               push_ready,
  output logic                               push,
  output logic [COIL_W+4*ANGLE_BITS-1:0]     push_data
);

  logic [ANGLE_BITS-1:0] offs;
  logic [ANGLE_BITS-1:0] adv;
  logic [ANGLE_BITS-1:0] cnt;
  logic [ANGLE_BITS-1:0] fin;
  logic [ANGLE_BITS-1:0] dw;
  logic [DWELL_W-1:0]    dw_clamp;
  logic                  coil_ok;

  always_comb begin
    offs = ANGLE_BITS'(tooth.payload.min_advance_angle);
    adv  = ANGLE_BITS'(tooth.payload.applied_advance);
    cnt  = ANGLE_BITS'(tooth.payload.crank_angle);
    fin  = ANGLE_BITS'(wrap_diff(ANG_MAX_W'(offs), ANG_MAX_W'(adv),
                                 cfg.engine_cycle_angle));
    if (tooth.payload.dwell_angle > {1'b0, cfg.dwell_angle_limit}) begin
      dw_clamp = {1'b0, cfg.dwell_angle_limit};
    end else begin
      dw_clamp = tooth.payload.dwell_angle;
    end
    dw      = ANGLE_BITS'(dw_clamp);
    coil_ok = 5'(tooth.payload.coil_index) < 5'(NUM_COILS);
  end

  // out-of-range coils are taken and dropped here
  assign tooth.ready = push_ready;
  assign push        = tooth.valid && push_ready && coil_ok;
  assign push_data   = {tooth.payload.coil_index, offs, cnt, fin, dw};

endmodule

`default_nettype wire

@@ sv/igds_queue.sv @@
// ----------------------------------------------------------------------------
// igds_queue
// Small FIFO between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module igds_queue import igds_pkg::*; #(
  parameter int WIDTH = COIL_W + 4 * DEF_ANGLE_BITS,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/igds_back.sv @@
// ----------------------------------------------------------------------------
// igds_back
// Window check, conduction start, slope points; three stages to the result.
// ----------------------------------------------------------------------------
`default_nettype none

module igds_back import igds_pkg::*; #(
  parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  logic                           head_valid,
  input  logic [COIL_W+4*ANGLE_BITS-1:0] head_data,
  output logic                           pop,
  igds_sched_if.source                   sched
);

  localparam int PROD_W = ANGLE_BITS + RATIO_W;

  // head fields
  logic [COIL_W-1:0]     h_coil;
  logic [ANGLE_BITS-1:0] h_offs;
  logic [ANGLE_BITS-1:0] h_cnt;
  logic [ANGLE_BITS-1:0] h_fin;
  logic [ANGLE_BITS-1:0] h_dw;

  logic [ANGLE_BITS-1:0] gap_to_spark;
  logic [ANGLE_BITS-1:0] start0;
  logic                  pass;
  logic                  now;

  // stage 1
  logic                  v1;
  logic [COIL_W-1:0]     coil1;
  logic                  now1;
  logic [ANGLE_BITS-1:0] start1;
  logic [ANGLE_BITS-1:0] fin1;
  logic [ANGLE_BITS-1:0] dwell1;

  // stage 2
  logic                  v2;
  logic [COIL_W-1:0]     coil2;
  logic                  now2;
  logic [ANGLE_BITS-1:0] start2;
  logic [ANGLE_BITS-1:0] fin2;
  logic [PROD_W-1:0]     prod_one;
  logic [PROD_W-1:0]     prod_two;

  // result stage
  logic                  res_valid;
  sched_t                res;
  sched_t                res_next;
  logic [ANGLE_BITS-1:0] hi_one;
  logic [ANGLE_BITS-1:0] hi_two;
  logic [ANGLE_BITS-1:0] abs_one;
  logic [ANGLE_BITS-1:0] abs_two;

  logic rdy_res;
  logic rdy2;
  logic rdy1;

  assign {h_coil, h_offs, h_cnt, h_fin, h_dw} = head_data;

  assign rdy_res = !res_valid || sched.ready;
  assign rdy2    = !v2 || rdy_res;
  assign rdy1    = !v1 || rdy2;
  assign pop     = head_valid && rdy1;

  always_comb begin
    gap_to_spark = ANGLE_BITS'(wrap_diff(ANG_MAX_W'(h_fin), ANG_MAX_W'(h_cnt),
                                         cfg.engine_cycle_angle));
    pass   = {1'b0, ANG_MAX_W'(gap_to_spark)} <= 17'({cfg.tdc_offset_angle, 1'b0});
    start0 = ANGLE_BITS'(wrap_diff(ANG_MAX_W'(h_fin), ANG_MAX_W'(h_dw),
                                   cfg.engine_cycle_angle));
    // conduction window runs from start to the reference angle, maybe wrapped
    if (start0 < h_offs) begin
      now = (h_cnt >= start0) && (h_cnt < h_offs);
    end else begin
      now = (h_cnt < h_offs) || (h_cnt >= start0);
    end
  end

  always_comb begin
    hi_one  = prod_one[PROD_W-1:RATIO_W];
    hi_two  = prod_two[PROD_W-1:RATIO_W];
    // second abs point: start + s1 + s2 collapses to start + hi_two
    abs_one = ANGLE_BITS'(reduce_once(ANG_MAX_W'(ANGLE_BITS'(hi_one + start2)),
                                      cfg.engine_cycle_angle));
    abs_two = ANGLE_BITS'(reduce_once(ANG_MAX_W'(ANGLE_BITS'(hi_two + start2)),
                                      cfg.engine_cycle_angle));
    res_next.coil_out          = coil2;
    res_next.immediate_trigger = now2;
    res_next.start_angle       = FIELD_W'(start2);
    res_next.end_angle         = FIELD_W'(fin2);
    res_next.slope_one_rel     = FIELD_W'(hi_one);
    res_next.slope_two_rel     = FIELD_W'(ANGLE_BITS'(hi_two - hi_one));
    res_next.slope_one_abs     = FIELD_W'(abs_one);
    res_next.slope_two_abs     = FIELD_W'(abs_two);
    res_next.watchdog_delay    = cfg.watchdog_limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= pop && pass;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy_res) begin
        res_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      coil1  <= h_coil;
      now1   <= now;
      start1 <= now ? h_cnt : start0;
      fin1   <= h_fin;
      dwell1 <= now ? gap_to_spark : h_dw;
    end
    if (rdy2) begin
      coil2    <= coil1;
      now2     <= now1;
      start2   <= start1;
      fin2     <= fin1;
      prod_one <= PROD_W'(dwell1) * PROD_W'(cfg.first_slope_ratio);
      prod_two <= PROD_W'(dwell1) * PROD_W'(cfg.second_slope_ratio);
    end
    if (rdy_res) begin
      res <= res_next;
    end
  end

  assign sched.valid   = res_valid;
  assign sched.payload = res;

endmodule

`default_nettype wire

@@ sv/igds_checker.sv @@
// ----------------------------------------------------------------------------
// igds_checker
// Port-level checks on the schedule result channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module igds_checker import igds_pkg::*; #(
  parameter int NUM_COILS = DEF_NUM_COILS
) (
  input logic   clk,
  input logic   rst,
  input logic   sched_valid,
  input logic   sched_ready,
  input sched_t sched_payload
);

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    sched_valid && !sched_ready |=> sched_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    sched_valid && !sched_ready |=> $stable(sched_payload))
    else $error("result changed while stalled");

  a_coil_range: assert property (@(posedge clk) disable iff (rst)
    sched_valid |-> (int'(sched_payload.coil_out) < NUM_COILS))
    else $error("result for a coil that does not exist");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !sched_valid)
    else $error("result valid right after reset");

endmodule

bind ignition_dwell_angle_scheduler_core igds_checker #(
  .NUM_COILS (NUM_COILS)
) u_igds_checker (
  .clk           (clk),
  .rst           (rst),
  .sched_valid   (sched.valid),
  .sched_ready   (sched.ready),
  .sched_payload (sched.payload)
);

`default_nettype wire
